// ===== design/fcba_pkg.sv =====
// ----------------------------------------------------------------------------
// fcba_pkg
// Shared types and codes of the FAT chain block allocator.
// ----------------------------------------------------------------------------
package fcba_pkg;

    localparam int BLK_W = 10;
    localparam int ENT_W = 11;

    // request codes
    localparam logic [2:0] REQ_FORMAT = 3'd0;
    localparam logic [2:0] REQ_ALLOC  = 3'd1;
    localparam logic [2:0] REQ_FREE   = 3'd2;
    localparam logic [2:0] REQ_CHAIN  = 3'd3;
    localparam logic [2:0] REQ_LINK   = 3'd4;
    localparam logic [2:0] REQ_READ   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // register index
    localparam logic REG_ENTRIES = 1'b0;

    localparam logic [ENT_W-1:0] NIL         = 11'h7FF;
    localparam logic [ENT_W-1:0] ENT_MIN     = 11'd128;
    localparam logic [ENT_W-1:0] ENT_RESET   = 11'd256;
    localparam logic [BLK_W-1:0] COUNT_MAX   = 10'd1023;
    localparam int               ENT_CAP     = 1024;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [BLK_W-1:0] addr;
        logic [ENT_W-1:0] wdata;
    } t_mem_req;

endpackage

// ===== design/fat_chain_block_allocator.sv =====
// ----------------------------------------------------------------------------
// fat_chain_block_allocator
// FAT-style next-block table with a linked free list and free-block count.
//
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_ready   i_req_type, i_block_index, i_link_target
// result    out        o_valid / i_ready   o_result_block, o_status, o_free_count,
//                                          o_chain_length
// config    in         psel/penable/pwrite paddr, pwdata, prdata (pready high)
//
// One request at a time. Free, link, unknown codes and any request refused by
// status finish without a table read; allocate and read next do one table
// read each, allocate adds a write-back; free chain over L blocks does one
// table read per link; format of N entries writes each entry in turn.
// A finished result waits in the output register while the next request runs;
// a further result holds the input off until it moves. Reset: head 1, count 0.
// ----------------------------------------------------------------------------
module fat_chain_block_allocator
    import fcba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2:0]              i_req_type,
    input  logic [BLK_W-1:0]        i_block_index,
    input  logic signed [ENT_W-1:0] i_link_target,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [ENT_W-1:0] o_result_block,
    output logic [1:0]              o_status,
    output logic [BLK_W-1:0]        o_free_count,
    output logic [ENT_W-1:0]        o_chain_length
);

    localparam int LP_DEPTH = (MAX_BLOCKS < ENT_CAP) ? MAX_BLOCKS : ENT_CAP;

    logic [ENT_W-1:0] w_entries;
    logic [ENT_W-1:0] w_rdata;
    t_mem_req         w_mem;

    fcba_regs #(
        .LIMIT (LP_DEPTH)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_entries (w_entries)
    );

    fcba_table #(
        .DEPTH (LP_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    fcba_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entries      (w_entries),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_block_index  (i_block_index),
        .i_link_target  (i_link_target),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_block (o_result_block),
        .o_status       (o_status),
        .o_free_count   (o_free_count),
        .o_chain_length (o_chain_length),
        .o_mem          (w_mem),
        .i_rdata        (w_rdata)
    );

endmodule

// ===== design/fcba_regs.sv =====
// ----------------------------------------------------------------------------
// fcba_regs
// Configuration register port; delivers the clamped table size.
// ----------------------------------------------------------------------------
module fcba_regs
    import fcba_pkg::*;
#(
    parameter int LIMIT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [ENT_W-1:0] o_entries
);

    localparam logic [ENT_W-1:0] LP_LIM = ENT_W'(LIMIT);

    logic [ENT_W-1:0] r_table_entries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_entries <= ENT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ENTRIES)) begin
            r_table_entries <= pwdata[ENT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRIES) ? {21'd0, r_table_entries} : 32'd0;

    // clamp into [128, limit]
    always_comb begin
        if (r_table_entries < ENT_MIN) begin
            o_entries = ENT_MIN;
        end else if (r_table_entries > LP_LIM) begin
            o_entries = LP_LIM;
        end else begin
            o_entries = r_table_entries;
        end
    end

endmodule

// ===== design/fcba_table.sv =====
// ----------------------------------------------------------------------------
// fcba_table
// Next-block table: single-port synchronous memory, registered read.
// ----------------------------------------------------------------------------
module fcba_table
    import fcba_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic             i_clk,
    input  t_mem_req         i_req,
    output logic [ENT_W-1:0] o_rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/fcba_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcba_ctrl
// Request sequencer: reads, modifies and writes back the next-block table,
// holds the free-list head and count, and registers the result.
// ----------------------------------------------------------------------------
module fcba_ctrl
    import fcba_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [ENT_W-1:0]        i_entries,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2:0]              i_req_type,
    input  logic [BLK_W-1:0]        i_block_index,
    input  logic signed [ENT_W-1:0] i_link_target,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [ENT_W-1:0] o_result_block,
    output logic [1:0]              o_status,
    output logic [BLK_W-1:0]        o_free_count,
    output logic [ENT_W-1:0]        o_chain_length,
    output t_mem_req                o_mem,
    input  logic [ENT_W-1:0]        i_rdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_FMT   = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_WCHK  = 3'd4;
    localparam logic [2:0] S_RDN   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    function automatic logic in_table(input logic [ENT_W-1:0] v, input logic [ENT_W-1:0] n);
        return !v[ENT_W-1] && (v < n);
    endfunction

    function automatic logic [BLK_W-1:0] sat_add(input logic [BLK_W-1:0] total,
                                                 input logic [ENT_W-1:0] k);
        logic [ENT_W:0] sum;
        sum = {2'b00, total} + {1'b0, k};
        return (sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : sum[BLK_W-1:0];
    endfunction

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_req, n_req;
    logic [BLK_W-1:0] r_blk, n_blk;
    logic [ENT_W-1:0] r_tgt, n_tgt;
    logic [BLK_W-1:0] r_cur, n_cur;
    logic [ENT_W-1:0] r_chain, n_chain;
    logic [BLK_W-1:0] r_idx, n_idx;
    logic [ENT_W-1:0] r_head, n_head;
    logic [BLK_W-1:0] r_total, n_total;
    logic [ENT_W-1:0] r_res, n_res;
    logic [1:0]       r_stat, n_stat;
    logic [ENT_W-1:0] r_len, n_len;

    logic             r_o_valid;
    logic [ENT_W-1:0] r_o_res;
    logic [1:0]       r_o_stat;
    logic [BLK_W-1:0] r_o_cnt;
    logic [ENT_W-1:0] r_o_len;

    logic             w_blk_out;
    logic             w_load;
    logic [ENT_W-1:0] w_last;

    assign w_blk_out = ({1'b0, r_blk} >= i_entries);
    assign w_load    = (r_state == S_DONE) && (!r_o_valid || i_ready);
    assign w_last    = i_entries - 11'd1;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_blk   = r_blk;
        n_tgt   = r_tgt;
        n_cur   = r_cur;
        n_chain = r_chain;
        n_idx   = r_idx;
        n_head  = r_head;
        n_total = r_total;
        n_res   = r_res;
        n_stat  = r_stat;
        n_len   = r_len;
        o_mem   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req   = i_req_type;
                    n_blk   = i_block_index;
                    n_tgt   = i_link_target;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = NIL;
                n_stat  = ST_OK;
                n_len   = '0;
                n_state = S_DONE;
                case (r_req)
                    REQ_FORMAT: begin
                        n_idx   = '0;
                        n_state = S_FMT;
                    end
                    REQ_ALLOC: begin
                        if (r_total == '0) begin
                            n_stat = ST_FULL;
                        end else if (!in_table(r_head, i_entries)) begin
                            n_stat = ST_RANGE;
                        end else begin
                            o_mem.rd_en = 1'b1;
                            o_mem.addr  = r_head[BLK_W-1:0];
                            n_res       = r_head;
                            n_state     = S_ALLOC;
                        end
                    end
                    REQ_FREE: begin
                        if (w_blk_out) begin
                            n_stat = ST_RANGE;
                        end else begin
                            o_mem.wr_en = 1'b1;
                            o_mem.addr  = r_blk;
                            o_mem.wdata = r_head;
                            n_head      = {1'b0, r_blk};
                            n_total     = sat_add(r_total, 11'd1);
                        end
                    end
                    REQ_CHAIN: begin
                        if (w_blk_out) begin
                            n_stat = ST_RANGE;
                        end else begin
                            o_mem.rd_en = 1'b1;
                            o_mem.addr  = r_blk;
                            n_cur       = r_blk;
                            n_chain     = 11'd1;
                            n_state     = S_WCHK;
                        end
                    end
                    REQ_LINK: begin
                        if (w_blk_out || (r_tgt != NIL && !in_table(r_tgt, i_entries))) begin
                            n_stat = ST_RANGE;
                        end else begin
                            o_mem.wr_en = 1'b1;
                            o_mem.addr  = r_blk;
                            o_mem.wdata = r_tgt;
                        end
                    end
                    REQ_READ: begin
                        if (w_blk_out) begin
                            n_stat = ST_RANGE;
                        end else begin
                            o_mem.rd_en = 1'b1;
                            o_mem.addr  = r_blk;
                            n_state     = S_RDN;
                        end
                    end
                    default: ;
                endcase
            end
            S_FMT: begin
                // block 0 and the last block end their chains
                o_mem.wr_en = 1'b1;
                o_mem.addr  = r_idx;
                if (r_idx == '0 || {1'b0, r_idx} == w_last) begin
                    o_mem.wdata = NIL;
                end else begin
                    o_mem.wdata = {1'b0, r_idx} + 11'd1;
                end
                if ({1'b0, r_idx} == w_last) begin
                    n_head  = 11'd1;
                    n_total = w_last[BLK_W-1:0];
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 10'd1;
                end
            end
            S_ALLOC: begin
                o_mem.wr_en = 1'b1;
                o_mem.addr  = r_res[BLK_W-1:0];
                o_mem.wdata = NIL;
                n_head      = i_rdata;
                n_total     = r_total - 10'd1;
                n_state     = S_DONE;
            end
            S_WCHK: begin
                if (r_chain < i_entries && in_table(i_rdata, i_entries)) begin
                    // advance along the chain, fetch the next link
                    o_mem.rd_en = 1'b1;
                    o_mem.addr  = i_rdata[BLK_W-1:0];
                    n_cur       = i_rdata[BLK_W-1:0];
                    n_chain     = r_chain + 11'd1;
                end else begin
                    // splice the whole chain onto the free list
                    o_mem.wr_en = 1'b1;
                    o_mem.addr  = r_cur;
                    o_mem.wdata = r_head;
                    n_head      = {1'b0, r_blk};
                    n_total     = sat_add(r_total, r_chain);
                    n_len       = r_chain;
                    n_state     = S_DONE;
                end
            end
            S_RDN: begin
                n_res   = i_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= 11'd1;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_total <= n_total;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_blk   <= n_blk;
        r_tgt   <= n_tgt;
        r_cur   <= n_cur;
        r_chain <= n_chain;
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_stat  <= n_stat;
        r_len   <= n_len;
        if (w_load) begin
            r_o_res  <= r_res;
            r_o_stat <= r_stat;
            r_o_cnt  <= r_total;
            r_o_len  <= r_len;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_result_block = r_o_res;
    assign o_status       = r_o_stat;
    assign o_free_count   = r_o_cnt;
    assign o_chain_length = r_o_len;

endmodule

// ===== design/fcba_checker.sv =====
// ----------------------------------------------------------------------------
// fcba_checker
// Port-level checks on the allocator result channel.
// ----------------------------------------------------------------------------
module fcba_checker
    import fcba_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic signed [ENT_W-1:0] o_result_block,
    input logic [1:0]              o_status,
    input logic [BLK_W-1:0]        o_free_count,
    input logic [ENT_W-1:0]        o_chain_length
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_block) && $stable(o_status)
            && $stable(o_free_count) && $stable(o_chain_length))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_FULL || o_status == ST_RANGE))
        else $error("undefined status code");

    a_err_nil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_result_block == NIL && o_chain_length == '0)
        else $error("failed request returned a block");

    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_chain_length != '0 |-> o_status == ST_OK && o_result_block == NIL)
        else $error("chain length on a non-chain result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind fat_chain_block_allocator fcba_checker u_fcba_checker (.*);

// ===== test/fat_chain_block_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// fat_chain_block_allocator_tb
// Self-checking bench for the FAT chain block allocator. A directed table
// covers reset state, range errors, an empty free list, a broken list head,
// a bad chain pointer, a cyclic chain and count saturation. Random phases
// follow, each after its own write of the table size. A local copy of the next-block table
// predicts every result. Both handshakes see random gaps, and one long
// result stall backs the block up.
// ----------------------------------------------------------------------------
module fat_chain_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcba_pkg::*;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;

    localparam int     ITEMS_PER_PHASE = 195;
    localparam int     STALL_LONG      = 400;
    localparam int     HELD_MAX        = 64;
    localparam longint CYCLE_LIMIT     = 64'd8_000_000;

    typedef struct packed {
        logic signed [ENT_W-1:0] blk;
        logic [1:0]              status;
        logic [BLK_W-1:0]        count;
        logic [ENT_W-1:0]        chain;
    } t_fat_result;

    typedef struct packed {
        logic [2:0]              req;
        logic [BLK_W-1:0]        blk;
        logic signed [ENT_W-1:0] tgt;
    } t_fat_req;

    typedef struct packed {
        logic        cfg_en;
        logic [31:0] cfg_val;
        t_fat_req    item;
        logic        typed;
        t_fat_result want;
    } t_dir_row;

    localparam t_fat_result NO_CHECK = '0;

    localparam t_dir_row DIRECTED [25] = '{
        // nothing formatted yet: only requests that leave the table unread
        '{1'b0, 32'd0, '{REQ_ALLOC, 10'd0, 11'd0}, 1'b1,
          '{NIL, ST_FULL, 10'd0, 11'd0}},
        '{1'b0, 32'd0, '{REQ_READ, 10'd1023, NIL}, 1'b1,
          '{NIL, ST_RANGE, 10'd0, 11'd0}},
        '{1'b0, 32'd0, '{REQ_CHAIN, 10'd512, 11'd0}, 1'b1,
          '{NIL, ST_RANGE, 10'd0, 11'd0}},
        '{1'b0, 32'd0, '{REQ_FREE, 10'd256, 11'd0}, 1'b1,
          '{NIL, ST_RANGE, 10'd0, 11'd0}},
        '{1'b0, 32'd0, '{REQ_LINK, 10'd0, 11'h7FE}, 1'b1,
          '{NIL, ST_RANGE, 10'd0, 11'd0}},
        '{1'b0, 32'd0, '{REQ_LINK, 10'd255, 11'd1023}, 1'b1,
          '{NIL, ST_RANGE, 10'd0, 11'd0}},
        '{1'b0, 32'd0, '{REQ_SPARE_A, 10'd1023, 11'h400}, 1'b1,
          '{NIL, ST_OK, 10'd0, 11'd0}},
        '{1'b0, 32'd0, '{REQ_FORMAT, 10'd0, 11'd0}, 1'b1,
          '{NIL, ST_OK, 10'd255, 11'd0}},
        '{1'b0, 32'd0, '{REQ_ALLOC, 10'd0, 11'd0}, 1'b1,
          '{11'd1, ST_OK, 10'd254, 11'd0}},
        '{1'b0, 32'd0, '{REQ_ALLOC, 10'd0, 11'd0}, 1'b1,
          '{11'd2, ST_OK, 10'd253, 11'd0}},
        '{1'b0, 32'd0, '{REQ_READ, 10'd0, 11'd0}, 1'b1,
          '{NIL, ST_OK, 10'd253, 11'd0}},
        '{1'b0, 32'd0, '{REQ_READ, 10'd255, 11'd0}, 1'b1,
          '{NIL, ST_OK, 10'd253, 11'd0}},
        '{1'b0, 32'd0, '{REQ_LINK, 10'd1, 11'd2}, 1'b1,
          '{NIL, ST_OK, 10'd253, 11'd0}},
        '{1'b0, 32'd0, '{REQ_LINK, 10'd2, NIL}, 1'b1,
          '{NIL, ST_OK, 10'd253, 11'd0}},
        '{1'b0, 32'd0, '{REQ_CHAIN, 10'd1, 11'd0}, 1'b0, NO_CHECK},
        '{1'b0, 32'd0, '{REQ_READ, 10'd2, 11'd0}, 1'b0, NO_CHECK},
        // two blocks pointing at each other: the walk must stop at N
        '{1'b0, 32'd0, '{REQ_LINK, 10'd10, 11'd11}, 1'b0, NO_CHECK},
        '{1'b0, 32'd0, '{REQ_LINK, 10'd11, 11'd10}, 1'b0, NO_CHECK},
        '{1'b0, 32'd0, '{REQ_CHAIN, 10'd10, 11'd0}, 1'b0, NO_CHECK},
        '{1'b0, 32'd0, '{REQ_FREE, 10'd200, 11'd0}, 1'b0, NO_CHECK},
        // shrink the table: list head 200 and next of 127 fall outside it
        '{1'b1, 32'd128, '{REQ_ALLOC, 10'd0, 11'd0}, 1'b0, NO_CHECK},
        '{1'b0, 32'd0, '{REQ_CHAIN, 10'd127, 11'd0}, 1'b0, NO_CHECK},
        '{1'b1, 32'd1024, '{REQ_FORMAT, 10'd0, 11'd0}, 1'b1,
          '{NIL, ST_OK, 10'd1023, 11'd0}},
        '{1'b0, 32'd0, '{REQ_FREE, 10'd1023, 11'd0}, 1'b1,
          '{NIL, ST_OK, 10'd1023, 11'd0}},
        '{1'b0, 32'd0, '{REQ_ALLOC, 10'd0, 11'd0}, 1'b0, NO_CHECK}
    };

    // 0 and 2047 saturate; the value wider than 11 bits keeps its low 11 bits
    localparam logic [31:0] PHASE_ENTRIES [10] = '{
        32'd128, 32'd1024, 32'd0, 32'd2047, 32'd300,
        32'd512, 32'hFFFF_FA00, 32'd1000, 32'd129, 32'd256
    };

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [2:0]              paddr         = '0;
    logic [31:0]             pwdata        = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    i_valid       = 1'b0;
    logic                    o_ready;
    logic [2:0]              i_req_type    = '0;
    logic [BLK_W-1:0]        i_block_index = '0;
    logic signed [ENT_W-1:0] i_link_target = '0;
    logic                    o_valid;
    logic                    i_ready       = 1'b0;
    logic signed [ENT_W-1:0] o_result_block;
    logic [1:0]              o_status;
    logic [BLK_W-1:0]        o_free_count;
    logic [ENT_W-1:0]        o_chain_length;

    // local copy of the allocator state
    int               link_tab [ENT_CAP];
    bit               link_set [ENT_CAP];
    int               list_head   = 1;
    int               list_free   = 0;
    logic [ENT_W-1:0] entries_reg = ENT_RESET;

    int          held_blocks[$];
    t_fat_result pending_results[$];
    int          err_count     = 0;
    bit          hold_req      = 1'b0;
    bit          sender_steady = 1'b0;

    fat_chain_block_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_block_index  (i_block_index),
        .i_link_target  (i_link_target),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_block (o_result_block),
        .o_status       (o_status),
        .o_free_count   (o_free_count),
        .o_chain_length (o_chain_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_entries();
        int n;
        n = int'(entries_reg);
        if (n < int'(ENT_MIN)) n = int'(ENT_MIN);
        if (n > ENT_CAP) n = ENT_CAP;
        return n;
    endfunction

    function automatic bit in_range(int v, int n);
        return v >= 0 && v < n;
    endfunction

    function automatic void grow_free(int k);
        list_free = (list_free + k > int'(COUNT_MAX)) ? int'(COUNT_MAX) : list_free + k;
    endfunction

    function automatic t_fat_result apply_to_table(t_fat_req r);
        int          n;
        int          b;
        int          tgt;
        int          res;
        int          cur;
        int          len;
        logic [1:0]  st;
        t_fat_result out;
        n   = active_entries();
        b   = int'(r.blk);
        tgt = int'(r.tgt);
        res = -1;
        len = 0;
        st  = ST_OK;
        case (r.req)
            REQ_FORMAT: begin
                for (int i = 0; i < n; i++) begin
                    link_tab[i] = (i == 0 || i == n - 1) ? -1 : i + 1;
                    link_set[i] = 1'b1;
                end
                list_head = 1;
                list_free = n - 1;
            end
            REQ_ALLOC: begin
                if (list_free == 0) begin
                    st = ST_FULL;
                end else if (!in_range(list_head, n)) begin
                    st = ST_RANGE;
                end else begin
                    res           = list_head;
                    list_head     = link_tab[res];
                    link_tab[res] = -1;
                    list_free--;
                end
            end
            REQ_FREE: begin
                if (b >= n) begin
                    st = ST_RANGE;
                end else begin
                    link_tab[b] = list_head;
                    link_set[b] = 1'b1;
                    list_head   = b;
                    grow_free(1);
                end
            end
            REQ_CHAIN: begin
                if (b >= n) begin
                    st = ST_RANGE;
                end else begin
                    cur = b;
                    len = 1;
                    while (len < n && in_range(link_tab[cur], n)) begin
                        cur = link_tab[cur];
                        len++;
                    end
                    grow_free(len);
                    link_tab[cur] = list_head;
                    link_set[cur] = 1'b1;
                    list_head     = b;
                end
            end
            REQ_LINK: begin
                if (b >= n || (tgt != -1 && !in_range(tgt, n))) begin
                    st = ST_RANGE;
                end else begin
                    link_tab[b] = tgt;
                    link_set[b] = 1'b1;
                end
            end
            REQ_READ: begin
                if (b >= n) st = ST_RANGE;
                else res = link_tab[b];
            end
            default: ;
        endcase
        out.blk    = ENT_W'(res);
        out.status = st;
        out.count  = BLK_W'(list_free);
        out.chain  = ENT_W'(len);
        return out;
    endfunction

    // true when the request would read a table entry that was never written
    function automatic bit reads_unset_entry(t_fat_req r);
        int n;
        int b;
        int cur;
        int len;
        n = active_entries();
        b = int'(r.blk);
        case (r.req)
            REQ_ALLOC: return list_free != 0 && in_range(list_head, n) && !link_set[list_head];
            REQ_READ:  return b < n && !link_set[b];
            REQ_CHAIN: begin
                if (b >= n) return 1'b0;
                cur = b;
                len = 1;
                while (len < n) begin
                    if (!link_set[cur]) return 1'b1;
                    if (!in_range(link_tab[cur], n)) return 1'b0;
                    cur = link_tab[cur];
                    len++;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // mostly a block handed out earlier, now and then any block in the table
    function automatic int pick_held(int n, bit take);
        int k;
        int b;
        if (held_blocks.size() == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, n - 1);
        k = $urandom_range(0, held_blocks.size() - 1);
        b = held_blocks[k];
        if (take) held_blocks.delete(k);
        return b;
    endfunction

    function automatic t_fat_req next_random_request();
        t_fat_req r;
        int       n;
        int       pick;
        n     = active_entries();
        r.req = REQ_READ;
        r.blk = BLK_W'($urandom);
        r.tgt = ENT_W'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 24) begin
            r.req = REQ_ALLOC;
        end else if (pick < 38) begin
            r.req = REQ_FREE;
            r.blk = BLK_W'(pick_held(n, 1'b1));
        end else if (pick < 56) begin
            r.req = REQ_LINK;
            r.blk = BLK_W'(pick_held(n, 1'b0));
            pick  = $urandom_range(0, 19);
            if (pick < 4) r.tgt = NIL;
            else if (pick < 17) r.tgt = ENT_W'(pick_held(n, 1'b0));
        end else if (pick < 70) begin
            r.req = REQ_CHAIN;
            r.blk = BLK_W'(pick_held(n, 1'b1));
        end else if (pick < 86) begin
            if ($urandom_range(0, 9) != 0) r.blk = BLK_W'($urandom_range(0, n - 1));
        end else if (pick < 90) begin
            r.req = REQ_FORMAT;
        end else begin
            r.req = 3'($urandom);
        end
        // a format writes every entry in use, so it is always safe
        if (reads_unset_entry(r)) r.req = REQ_FORMAT;
        return r;
    endfunction

    task automatic send_request(t_fat_req r, bit typed, t_fat_result want);
        int          gap;
        t_fat_result got;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= r.req;
        i_block_index <= r.blk;
        i_link_target <= r.tgt;
        do @(posedge i_clk); while (!o_ready);
        got = apply_to_table(r);
        pending_results.push_back(typed ? want : got);
        if (r.req == REQ_ALLOC && got.status == ST_OK) begin
            held_blocks.push_back(int'(got.blk));
            if (held_blocks.size() > HELD_MAX) held_blocks.delete(0);
        end
    endtask

    // wait for the block to go idle, then write the table size
    task automatic settle_and_write(logic [31:0] value);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_ENTRIES, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        entries_reg = value[ENT_W-1:0];
    endtask

    function automatic void compare_field(string name, logic signed [15:0] want,
                                          logic signed [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    task automatic check_result();
        t_fat_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result block %0d status %0d count %0d chain %0d",
                     $time, o_result_block, o_status, o_free_count, o_chain_length);
            err_count++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("result_block", want.blk, o_result_block);
        compare_field("status", want.status, o_status);
        compare_field("free_count", want.count, o_free_count);
        compare_field("chain_length", want.chain, o_chain_length);
    endtask

    initial begin : result_sink
        int run_left;
        int pick;
        bit run_ready;
        run_left  = 0;
        run_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) check_result();
            if (run_left == 0) begin
                if (hold_req) begin
                    // long hold-off: let the block back up into its input
                    hold_req  = 1'b0;
                    run_ready = 1'b0;
                    run_left  = STALL_LONG;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10) begin
                        run_ready = 1'b1;
                        run_left  = $urandom_range(80, 200);
                    end else if (pick < 55) begin
                        run_ready = 1'b1;
                        run_left  = $urandom_range(1, 12);
                    end else begin
                        run_ready = 1'b0;
                        run_left  = pick_gap() + 1;
                    end
                end
            end
            run_left--;
            i_ready <= run_ready;
        end
    end

    initial begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("fat_chain_block_allocator_tb: errors");
        $finish;
    end

    initial begin : stimulus
        t_dir_row row;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) begin
            row = DIRECTED[k];
            if (row.cfg_en) settle_and_write(row.cfg_val);
            send_request(row.item, row.typed, row.want);
        end

        foreach (PHASE_ENTRIES[p]) begin
            settle_and_write(PHASE_ENTRIES[p]);
            sender_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 1 && k == 40) hold_req = 1'b1;
                send_request(next_random_request(), 1'b0, NO_CHECK);
            end
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("fat_chain_block_allocator_tb: clean");
        end else begin
            $display("fat_chain_block_allocator_tb: errors");
        end
        $finish;
    end

endmodule

// ===== fat_chain_block_allocator.f =====
design/fcba_pkg.sv
design/fcba_regs.sv
design/fcba_table.sv
design/fcba_ctrl.sv
design/fat_chain_block_allocator.sv
design/fcba_checker.sv
test/fat_chain_block_allocator_tb.sv
